// ===== hw/rtl/tccm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccm_pkg
// Shared widths, register indexes, rotation codes and helpers of the touch
// calibrated coordinate map.
// ----------------------------------------------------------------------------
package tccm_pkg;

	localparam int PANEL_WIDTH  = 240;
	localparam int PANEL_HEIGHT = 64;
	localparam int PANEL_MAX    = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;

	localparam int RAW_W   = 10;
	localparam int PRES_W  = 16;
	localparam int SCR_W   = 8;
	localparam int COEF_W  = 32;
	localparam int ROT_W   = 2;
	localparam int CFG_IDX_W = 3;

	// quotient bits needed to reach the panel limit
	localparam int QW     = $clog2(PANEL_MAX);
	localparam int CW     = QW + 1;
	localparam int MUL_W  = COEF_W + RAW_W + 1;
	localparam int NUM_W  = MUL_W + 2;
	localparam int REM_W  = COEF_W + QW;

	// abs, saturation check, one stage per quotient bit, clamp
	localparam int DIV_LAT  = QW + 3;
	// products, sums, divider, rotation
	localparam int PIPE_LAT = DIV_LAT + 3;

	localparam logic [QW-1:0] LIM_X = QW'(PANEL_WIDTH - 1);
	localparam logic [QW-1:0] LIM_Y = QW'(PANEL_HEIGHT - 1);
	localparam logic [CW-1:0] EDGE_X = CW'(PANEL_WIDTH);
	localparam logic [CW-1:0] EDGE_Y = CW'(PANEL_HEIGHT);

	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_F = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DET    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROT    = 3'd7;

	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	function automatic logic [SCR_W-1:0] fit_scr(input logic [CW-1:0] v);
		logic [CW+SCR_W-1:0] wide;
		wide = {{SCR_W{1'b0}}, v};
		return wide[SCR_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/tccm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccm stream interfaces
// Raw touch point channel and mapped screen point channel.
// ----------------------------------------------------------------------------
interface tccm_raw_if;
	import tccm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [RAW_W-1:0]         raw_x;
	logic [RAW_W-1:0]         raw_y;
	logic signed [PRES_W-1:0] raw_pressure;

	modport source (output valid, raw_x, raw_y, raw_pressure, input ready);
	modport sink   (input valid, raw_x, raw_y, raw_pressure, output ready);
endinterface

interface tccm_scr_if;
	import tccm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [SCR_W-1:0]         screen_x;
	logic [SCR_W-1:0]         screen_y;
	logic signed [PRES_W-1:0] pressure_out;
	logic                     uncalibrated;

	modport source (output valid, screen_x, screen_y, pressure_out, uncalibrated, input ready);
	modport sink   (input valid, screen_x, screen_y, pressure_out, uncalibrated, output ready);
endinterface

// ===== hw/rtl/touch_calibrated_coordinate_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_calibrated_coordinate_map
// Maps a raw touch point to panel coordinates with a three-point affine
// calibration, clamps to the panel, rotates, and passes pressure through.
// Pipeline: products, sums, the one-bit-per-stage divider, then rotation
// into the output register.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: arst_n clears all valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
module touch_calibrated_coordinate_map import tccm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	tccm_raw_if.sink             raw,
	tccm_scr_if.source           screen
);

	logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
	logic signed [COEF_W-1:0] coef_d_q, coef_e_q, coef_f_q;
	logic signed [COEF_W-1:0] det_q;
	logic [ROT_W-1:0]         rot_q;

	logic en;

	logic                     vld_st  [PIPE_LAT];
	logic signed [PRES_W-1:0] pres_st [PIPE_LAT];

	logic signed [MUL_W-1:0] ax_s1, by_s1, dx_s1, ey_s1;
	logic signed [MUL_W-1:0] xe, ye;
	logic signed [NUM_W-1:0] numx_s2, numy_s2;

	logic [QW-1:0] px, py;
	logic [CW-1:0] pxw, pyw;
	logic [CW-1:0] sx, sy;

	logic [SCR_W-1:0] sx_so, sy_so;
	logic             uncal_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
			coef_d_q <= '0;
			coef_e_q <= '0;
			coef_f_q <= '0;
			det_q    <= '0;
			rot_q    <= ROT_0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				REG_COEF_D: coef_d_q <= cfg_data;
				REG_COEF_E: coef_e_q <= cfg_data;
				REG_COEF_F: coef_f_q <= cfg_data;
				REG_DET:    det_q    <= cfg_data;
				REG_ROT:    rot_q    <= cfg_data[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless a result waits in the output register
	assign en        = !vld_st[PIPE_LAT-1] || screen.ready;
	assign raw.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_st[i] <= 1'b0;
			end
		end else if (en) begin
			vld_st[0] <= raw.valid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_st[i] <= vld_st[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pres_st[0] <= raw.raw_pressure;
			for (int i = 1; i < PIPE_LAT; i++) begin
				pres_st[i] <= pres_st[i-1];
			end
		end
	end

	// stage 1: products
	assign xe = MUL_W'($signed({1'b0, raw.raw_x}));
	assign ye = MUL_W'($signed({1'b0, raw.raw_y}));

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= MUL_W'(coef_a_q) * xe;
			by_s1 <= MUL_W'(coef_b_q) * ye;
			dx_s1 <= MUL_W'(coef_d_q) * xe;
			ey_s1 <= MUL_W'(coef_e_q) * ye;
		end
	end

	// stage 2: numerators
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= NUM_W'(ax_s1) + NUM_W'(by_s1) + NUM_W'(coef_c_q);
			numy_s2 <= NUM_W'(dx_s1) + NUM_W'(ey_s1) + NUM_W'(coef_f_q);
		end
	end

	tccm_div u_div_x (
		.clk     (clk),
		.en      (en),
		.num     (numx_s2),
		.det     (det_q),
		.lim_max (LIM_X),
		.q       (px)
	);

	tccm_div u_div_y (
		.clk     (clk),
		.en      (en),
		.num     (numy_s2),
		.det     (det_q),
		.lim_max (LIM_Y),
		.q       (py)
	);

	// rotation, edge values kept
	assign pxw = CW'(px);
	assign pyw = CW'(py);

	always_comb begin
		case (rot_q)
			ROT_0: begin
				sx = pxw;
				sy = pyw;
			end
			ROT_90: begin
				sx = pyw;
				sy = EDGE_X - pxw;
			end
			ROT_180: begin
				sx = EDGE_X - pxw;
				sy = EDGE_Y - pyw;
			end
			ROT_270: begin
				sx = EDGE_Y - pyw;
				sy = pxw;
			end
			default: begin
				sx = pxw;
				sy = pyw;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (det_q == '0) begin
				sx_so    <= '0;
				sy_so    <= '0;
				uncal_so <= 1'b1;
			end else begin
				sx_so    <= fit_scr(sx);
				sy_so    <= fit_scr(sy);
				uncal_so <= 1'b0;
			end
		end
	end

	assign screen.valid        = vld_st[PIPE_LAT-1];
	assign screen.screen_x     = sx_so;
	assign screen.screen_y     = sy_so;
	assign screen.pressure_out = pres_st[PIPE_LAT-1];
	assign screen.uncalibrated = uncal_so;

	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		screen.valid && screen.uncalibrated |-> screen.screen_x == '0 && screen.screen_y == '0)
		else $error("uncalibrated result with nonzero coordinates");

	a_hold_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!raw.ready |-> screen.valid && !screen.ready)
		else $error("input held off without a stalled output");

	a_stall_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		screen.valid && !screen.ready |=> screen.valid && $stable(screen.pressure_out))
		else $error("stalled result lost or changed");

endmodule

// ===== hw/rtl/tccm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccm_div
// Pipelined restoring divider, one quotient bit per stage, with the result
// truncated toward zero and clamped to 0..lim_max.
// ----------------------------------------------------------------------------
module tccm_div import tccm_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [NUM_W-1:0]  num,
	input  logic signed [COEF_W-1:0] det,
	input  logic [QW-1:0]            lim_max,
	output logic [QW-1:0]            q
);

	logic              neg_s1;
	logic [NUM_W-1:0]  anum_s1;
	logic [COEF_W-1:0] adet_s1;

	logic              neg_st  [QW+1];
	logic              sat_st  [QW+1];
	logic [COEF_W-1:0] adet_st [QW+1];
	logic [REM_W-1:0]  rem_st  [QW+1];
	logic [QW-1:0]     quo_st  [QW+1];

	logic [QW-1:0]     q_so;

	// magnitudes, negative quotient clamps to zero
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= num[NUM_W-1] ^ det[COEF_W-1];
			anum_s1 <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			adet_s1 <= det[COEF_W-1] ? COEF_W'(-det) : COEF_W'(det);
		end
	end

	// quotient at or above 2^QW saturates
	always_ff @(posedge clk) begin
		if (en) begin
			neg_st[0]  <= neg_s1;
			sat_st[0]  <= anum_s1 >= NUM_W'({adet_s1, {QW{1'b0}}});
			adet_st[0] <= adet_s1;
			rem_st[0]  <= anum_s1[REM_W-1:0];
			quo_st[0]  <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = REM_W'(adet_st[j]) << (QW - 1 - j);
		assign take  = rem_st[j] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_st[j+1]  <= neg_st[j];
				sat_st[j+1]  <= sat_st[j];
				adet_st[j+1] <= adet_st[j];
				rem_st[j+1]  <= take ? rem_st[j] - trial : rem_st[j];
				quo_st[j+1]  <= {quo_st[j][QW-2:0], take};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_st[QW]) begin
				q_so <= '0;
			end else if (sat_st[QW] || (quo_st[QW] > lim_max)) begin
				q_so <= lim_max;
			end else begin
				q_so <= quo_st[QW];
			end
		end
	end

	assign q = q_so;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the touch calibrated coordinate map: every accepted raw touch point
// is mapped by a local model of the affine calibration, clamp and rotation,
// and the screen points that come out are compared in order. Directed points
// cover reset, edge values and coefficient extremes; random phases load new
// calibrations and drive both channels with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
	import tccm_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 11;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 16;
	localparam int POINTS_PER_PHASE = 100;

	localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;
	localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [SCR_W-1:0]  sx;
		logic [SCR_W-1:0]  sy;
		logic [PRES_W-1:0] pres;
		logic              uncal;
	} screen_point_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	tccm_raw_if raw_ch ();
	tccm_scr_if scr_ch ();

	touch_calibrated_coordinate_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.raw       (raw_ch),
		.screen    (scr_ch)
	);

	// calibration as the block should hold it
	longint           cal_a, cal_b, cal_c, cal_d, cal_e, cal_f;
	longint           cal_det;
	logic [ROT_W-1:0] cal_rot;

	screen_point_t expected_points[$];
	screen_point_t want_point;
	int            error_count = 0;
	int            quiet_cycles = 0;
	int            burst_left = 0;
	int            tx_gap_max = 3;
	int            rx_mode = 0;
	int            rx_tick = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clamp_quotient(input longint w_x, w_y, w_off,
			input longint x, y, input longint top);
		longint num;
		longint q;
		num = w_x * x + w_y * y + w_off;
		q = num / cal_det;
		if (q < 0)
			q = 0;
		else if (q >= top)
			q = top - 1;
		return q;
	endfunction

	function automatic screen_point_t map_touch(input logic [RAW_W-1:0] x, y,
			input logic [PRES_W-1:0] pres);
		screen_point_t pt;
		longint px;
		longint py;
		longint sx;
		longint sy;
		pt.pres = pres;
		pt.uncal = (cal_det == 0);
		sx = 0;
		sy = 0;
		if (cal_det != 0) begin
			px = clamp_quotient(cal_a, cal_b, cal_c, longint'(x), longint'(y), PANEL_WIDTH);
			py = clamp_quotient(cal_d, cal_e, cal_f, longint'(x), longint'(y), PANEL_HEIGHT);
			case (cal_rot)
				ROT_0: begin
					sx = px;
					sy = py;
				end
				ROT_90: begin
					sx = py;
					sy = PANEL_WIDTH - px;
				end
				ROT_180: begin
					sx = PANEL_WIDTH - px;
					sy = PANEL_HEIGHT - py;
				end
				default: begin
					sx = PANEL_HEIGHT - py;
					sy = px;
				end
			endcase
		end
		pt.sx = SCR_W'(sx);
		pt.sy = SCR_W'(sy);
		return pt;
	endfunction

	task automatic send_touch(input logic [RAW_W-1:0] x, y, input logic [PRES_W-1:0] pres);
		int gap;
		if (burst_left == 0) begin
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				raw_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		raw_ch.valid        <= 1'b1;
		raw_ch.raw_x        <= x;
		raw_ch.raw_y        <= y;
		raw_ch.raw_pressure <= pres;
		do
			@(posedge clk);
		while (!raw_ch.ready);
		expected_points.push_back(map_touch(x, y, pres));
		burst_left--;
	endtask

	task automatic wait_pipeline_empty();
		raw_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_COEF_A: cal_a = longint'($signed(data));
			REG_COEF_B: cal_b = longint'($signed(data));
			REG_COEF_C: cal_c = longint'($signed(data));
			REG_COEF_D: cal_d = longint'($signed(data));
			REG_COEF_E: cal_e = longint'($signed(data));
			REG_COEF_F: cal_f = longint'($signed(data));
			REG_DET:    cal_det = longint'($signed(data));
			REG_ROT:    cal_rot = data[ROT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_calibration(input logic [COEF_W-1:0] a, b, c, d, e, f, det,
			input logic [ROT_W-1:0] rot);
		wait_pipeline_empty();
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
		write_reg(REG_COEF_D, d);
		write_reg(REG_COEF_E, e);
		write_reg(REG_COEF_F, f);
		write_reg(REG_DET, det);
		write_reg(REG_ROT, COEF_W'(rot));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// plausible calibration for one axis: scale per 1024 raw counts, small
	// cross term, offset, optionally mirrored
	function automatic void random_axis(input longint dd, input int k_lo, k_hi, span,
			output logic [COEF_W-1:0] w_main, w_cross, w_off);
		int k;
		int kc;
		int off;
		k = int'($urandom_range(k_lo, k_hi));
		kc = int'($urandom_range(0, 16)) - 8;
		off = int'($urandom_range(0, span / 3)) - span / 4;
		if ($urandom_range(0, 1)) begin
			k = -k;
			off = off + span;
		end
		w_main  = COEF_W'(dd * k / 1024);
		w_cross = COEF_W'(dd * kc / 1024);
		w_off   = COEF_W'(dd * off);
	endfunction

	task automatic test_uncalibrated_after_reset();
		send_touch(10'd0, 10'd0, 16'h8000);
		send_touch(10'h3FF, 10'h3FF, 16'h7FFF);
		send_touch(10'h2AA, 10'h155, 16'h5555);
	endtask

	task automatic test_rotation_edges();
		logic [ROT_W-1:0] rot;
		for (int r = 0; r < 4; r++) begin
			rot = ROT_W'(r);
			load_calibration(32'sd240, 32'sd0, 32'sd0, 32'sd0, 32'sd64, 32'sd0, 32'sd1024, rot);
			send_touch(10'd0, 10'd0, 16'hAAAA);
			send_touch(10'h3FF, 10'h3FF, 16'h0001);
			send_touch(10'd511, 10'd767, 16'hFFFF);
		end
	endtask

	task automatic test_coefficient_extremes();
		load_calibration(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
			32'hFFFF_FFFF, ROT_0);
		send_touch(10'd0, 10'd0, 16'h0000);
		send_touch(10'h3FF, 10'd0, 16'h8000);
		send_touch(10'd0, 10'h3FF, 16'h7FFF);
		load_calibration(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN,
			COEF_MIN, ROT_180);
		send_touch(10'h3FF, 10'h3FF, 16'h1234);
		send_touch(10'd512, 10'd1, 16'hEDCB);
		load_calibration(32'sd5, -32'sd3, 32'sd7, -32'sd2, 32'sd9, 32'sd1, -32'sd7, ROT_270);
		send_touch(10'd100, 10'd900, 16'h0F0F);
		// zero divisor after a valid calibration, rotated
		load_calibration(32'sd240, 32'sd0, 32'sd0, 32'sd0, 32'sd64, 32'sd0, 32'sd0, ROT_90);
		send_touch(10'd300, 10'd300, 16'hC000);
	endtask

	task automatic test_random_calibrations();
		logic [COEF_W-1:0] a, b, c, d, e, f, det;
		logic [COEF_W-1:0] xm, xc, xo, ym, yc, yo;
		logic [RAW_W-1:0]  x, y;
		longint            dd;
		int                kind;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				dd = longint'($urandom_range(1024, 1 << 20));
				if ($urandom_range(0, 1))
					dd = -dd;
				random_axis(dd, 200, 300, PANEL_WIDTH, xm, xc, xo);
				random_axis(dd, 50, 80, PANEL_HEIGHT, ym, yc, yo);
				if ($urandom_range(0, 1)) begin
					a = xc;
					b = xm;
					d = ym;
					e = yc;
				end else begin
					a = xm;
					b = xc;
					d = yc;
					e = ym;
				end
				c = xo;
				f = yo;
				det = COEF_W'(dd);
			end else if (kind < 82) begin
				a = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				b = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				c = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				d = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				e = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				f = COEF_W'(int'($urandom_range(0, 2000)) - 1000);
				det = COEF_W'(int'($urandom_range(1, 50)));
				if ($urandom_range(0, 1))
					det = -det;
			end else begin
				a = $urandom();
				b = $urandom();
				c = $urandom();
				d = $urandom();
				e = $urandom();
				f = $urandom();
				det = (kind < 95) ? $urandom() : '0;
			end
			tx_gap_max = (ph % 4 == 0) ? 0 : $urandom_range(1, 12);
			load_calibration(a, b, c, d, e, f, det, ROT_W'($urandom_range(0, 3)));
			for (int i = 0; i < POINTS_PER_PHASE; i++) begin
				x = ($urandom_range(0, 9) == 0) ? {RAW_W{$urandom_range(0, 1) == 1}}
					: RAW_W'($urandom_range(0, 1023));
				y = ($urandom_range(0, 9) == 0) ? {RAW_W{$urandom_range(0, 1) == 1}}
					: RAW_W'($urandom_range(0, 1023));
				send_touch(x, y, PRES_W'($urandom_range(0, 16'hFFFF)));
			end
		end
	endtask

	// result check and receiver stall pattern
	always @(posedge clk) begin
		if (scr_ch.valid && scr_ch.ready) begin
			if (expected_points.size() == 0) begin
				$error("screen point with no request pending");
				error_count++;
			end else begin
				want_point = expected_points.pop_front();
				if (scr_ch.screen_x !== want_point.sx) begin
					$error("screen_x: expected %0d, actual %0d", want_point.sx, scr_ch.screen_x);
					error_count++;
				end
				if (scr_ch.screen_y !== want_point.sy) begin
					$error("screen_y: expected %0d, actual %0d", want_point.sy, scr_ch.screen_y);
					error_count++;
				end
				if (scr_ch.pressure_out !== want_point.pres) begin
					$error("pressure_out: expected %0d, actual %0d",
						$signed(want_point.pres), scr_ch.pressure_out);
					error_count++;
				end
				if (scr_ch.uncalibrated !== want_point.uncal) begin
					$error("uncalibrated: expected %0d, actual %0d",
						want_point.uncal, scr_ch.uncalibrated);
					error_count++;
				end
			end
		end
		rx_tick++;
		if (rx_tick % 300 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: scr_ch.ready <= 1'b1;
			1: scr_ch.ready <= ($urandom_range(0, 3) != 0);
			2: scr_ch.ready <= ((rx_tick % 7) < 3);
			default: scr_ch.ready <= ($urandom_range(0, 9) < 2);
		endcase
	end

	always @(posedge clk) begin
		if ((raw_ch.valid && raw_ch.ready) || (scr_ch.valid && scr_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		raw_ch.valid        <= 1'b0;
		raw_ch.raw_x        <= '0;
		raw_ch.raw_y        <= '0;
		raw_ch.raw_pressure <= '0;
		cal_a   = 0;
		cal_b   = 0;
		cal_c   = 0;
		cal_d   = 0;
		cal_e   = 0;
		cal_f   = 0;
		cal_det = 0;
		cal_rot = ROT_0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_uncalibrated_after_reset();
		test_rotation_edges();
		test_coefficient_extremes();
		test_random_calibrations();
		wait_pipeline_empty();
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
